/* hw/rtl/bldc_pkg.sv */
// ----------------------------------------------------------------------------
// bldc_pkg
// Shared types, codes and the commutation table of the six-step commutator.
// ----------------------------------------------------------------------------
`default_nettype none

package bldc_pkg;

    // Tick counter width and the compare width against step_time.
    localparam int TICK_BITS    = 16;
    localparam int STEP_BITS    = 16;
    localparam int CMP_BITS     = (TICK_BITS > STEP_BITS) ? TICK_BITS : STEP_BITS;
    localparam int CFG_IDX_BITS = 1;

    // Run states.
    localparam logic [1:0] RS_STOP   = 2'd0;
    localparam logic [1:0] RS_SINGLE = 2'd1;
    localparam logic [1:0] RS_CONT   = 2'd2;

    // Item kinds (tuser).
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_CMD  = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_TIME = 1'd1;

    localparam logic [STEP_BITS-1:0] STEP_TIME_RESET = 16'd50;
    localparam logic [2:0]           LAST_SECTOR     = 3'd5;

    typedef struct packed {
        logic                 direction;
        logic [STEP_BITS-1:0] step_time;
    } bldc_cfg_t;

    // Result item, packed in tdata order from the top down.
    typedef struct packed {
        logic [1:0] run_state;
        logic [2:0] sector;
        logic [5:0] gate_enables;
    } bldc_result_t;

    // bit0 U+, bit1 U-, bit2 V+, bit3 V-, bit4 W+, bit5 W-
    function automatic logic [5:0] gate_row(input logic [2:0] sector);
        logic [5:0] row;
        unique case (sector)
            3'd0:    row = 6'h09;
            3'd1:    row = 6'h21;
            3'd2:    row = 6'h24;
            3'd3:    row = 6'h06;
            3'd4:    row = 6'h12;
            3'd5:    row = 6'h18;
            default: row = 6'h00;
        endcase
        return row;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bldc_state.sv */
// ----------------------------------------------------------------------------
// bldc_step_core
// Run state, sector and tick counter; one item is applied per accepted cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_step_core (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_fire,
    input  wire logic                   in_mode,
    input  wire logic [1:0]             in_req,
    input  wire bldc_pkg::bldc_cfg_t    cfg,
    output bldc_pkg::bldc_result_t      result
);

    logic [1:0]                     run_reg, run_next;
    logic [2:0]                     sector_reg, sector_next;
    logic [bldc_pkg::TICK_BITS-1:0] tick_reg, tick_next;
    logic                           gates_reg, gates_next;

    logic [2:0]                     sector_adv;
    logic [bldc_pkg::TICK_BITS-1:0] tick_inc;
    logic                           tick_done;

    // Neighbor sector, wrapping mod 6.
    always_comb begin
        if (cfg.direction == 1'b0) begin
            sector_adv = (sector_reg == bldc_pkg::LAST_SECTOR) ? 3'd0 : sector_reg + 3'd1;
        end else begin
            sector_adv = (sector_reg == 3'd0) ? bldc_pkg::LAST_SECTOR : sector_reg - 3'd1;
        end
    end

    assign tick_inc  = tick_reg + 1'b1;
    assign tick_done = bldc_pkg::CMP_BITS'(tick_inc) >= bldc_pkg::CMP_BITS'(cfg.step_time);

    always_comb begin
        run_next    = run_reg;
        sector_next = sector_reg;
        tick_next   = tick_reg;
        gates_next  = gates_reg;
        if (in_mode == bldc_pkg::MODE_CMD) begin
            if (in_req == bldc_pkg::RS_SINGLE || in_req == bldc_pkg::RS_CONT) begin
                run_next = in_req;
            end else begin
                run_next   = bldc_pkg::RS_STOP;
                gates_next = 1'b0;
            end
        end else begin
            unique case (run_reg)
                bldc_pkg::RS_SINGLE: begin
                    if (tick_reg == '0) begin
                        sector_next = sector_adv;
                        gates_next  = 1'b1;
                    end
                    tick_next = tick_inc;
                    if (tick_done) begin
                        tick_next  = '0;
                        gates_next = 1'b0;
                        run_next   = bldc_pkg::RS_STOP;
                    end
                end
                bldc_pkg::RS_CONT: begin
                    tick_next = tick_inc;
                    if (tick_done) begin
                        tick_next   = '0;
                        sector_next = sector_adv;
                        gates_next  = 1'b1;
                    end
                end
                default: begin
                    run_next   = bldc_pkg::RS_STOP;
                    gates_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= bldc_pkg::RS_STOP;
            sector_reg <= 3'd0;
            tick_reg   <= '0;
            gates_reg  <= 1'b0;
        end else if (in_fire) begin
            run_reg    <= run_next;
            sector_reg <= sector_next;
            tick_reg   <= tick_next;
            gates_reg  <= gates_next;
        end
    end

    // Result reflects the state after this item.
    assign result.run_state    = run_next;
    assign result.sector       = sector_next;
    assign result.gate_enables = gates_next ? bldc_pkg::gate_row(sector_next) : 6'h00;

    a_sector_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sector_reg <= bldc_pkg::LAST_SECTOR)
        else $error("sector out of range");

    a_stop_gates_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg == bldc_pkg::RS_STOP) |-> !gates_reg)
        else $error("gates active while stopped");

    a_stop_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_mode == bldc_pkg::MODE_CMD && in_req == bldc_pkg::RS_STOP)
        |=> (run_reg == bldc_pkg::RS_STOP && !gates_reg))
        else $error("stop command not applied");

endmodule

`default_nettype wire

/* hw/rtl/bldc_out_fifo.sv */
// ----------------------------------------------------------------------------
// bldc_out_fifo
// Two-entry result buffer; decouples the input side from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_out_fifo (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire bldc_pkg::bldc_result_t push_data,
    output logic                        full,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output bldc_pkg::bldc_result_t      out_data
);

    bldc_pkg::bldc_result_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("fifo count overflow");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full fifo");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("fifo pointers disagree with count");

endmodule

`default_nettype wire

/* hw/rtl/bldc_six_step_commutator.sv */
// ----------------------------------------------------------------------------
// bldc_six_step_commutator
// Open-loop six-step BLDC commutator with stream input and output.
// ----------------------------------------------------------------------------
// Each input item is either a timer tick (tuser = 0) or a run-state command
// (tuser = 1, tdata[1:0] = 0 stop, 1 single step, 2 continuous; 3 acts as
// stop). Every item yields exactly one result item carrying the gate enables,
// the sector and the run state after that item. Items are taken at one per
// clock: the state update is a counter compare and a mod-6 sector step done
// in the cycle the item is accepted, and the result lands in a two-entry
// output buffer, so the input stays ready while one result waits downstream
// and stalls only when two results are pending. m_tvalid rises in the cycle
// after acceptance. Registers (write only when idle): index 0 is
// direction (0 forward, 1 reverse), index 1 is step_time (ticks per step, or
// the single-step hold, reset 50). Commands never clear the tick count.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_six_step_commutator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // Input items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [1:0] new_run_state
    input  wire logic [0:0]                          s_tuser,   // [0] mode

    // Result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,   // [5:0] gate_enables,
                                                                // [8:6] sector,
                                                                // [10:9] run_state

    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bldc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [bldc_pkg::STEP_BITS-1:0]      cfg_data
);

    bldc_pkg::bldc_cfg_t    cfg_reg;
    bldc_pkg::bldc_result_t step_result;
    bldc_pkg::bldc_result_t out_result;
    logic                   fifo_full;
    logic                   in_fire;

    // Register writes are always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.direction <= 1'b0;
            cfg_reg.step_time <= bldc_pkg::STEP_TIME_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bldc_pkg::REG_DIRECTION: cfg_reg.direction <= cfg_data[0];
                bldc_pkg::REG_STEP_TIME: cfg_reg.step_time <= cfg_data;
                default: ;
            endcase
        end
    end

    // Accept whenever the result buffer has room.
    assign s_tready = !fifo_full;
    assign in_fire  = s_tvalid && s_tready;

    bldc_step_core u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_mode (s_tuser[0]),
        .in_req  (s_tdata[1:0]),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    bldc_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (step_result),
        .full      (fifo_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {5'd0, out_result};

    // A stall on the output must not drop or duplicate: m_tdata holds while
    // the downstream side waits.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_tvalid)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire
